[design/advection_diffusion_cell_update_assert.svh]
// Assertion macros shared by the cell update RTL.
`ifndef ADVECTION_DIFFUSION_CELL_UPDATE_ASSERT_SVH
`define ADVECTION_DIFFUSION_CELL_UPDATE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define ADC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define ADC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/adc_pkg.sv]
// Types, constants and helper functions of the cell update pipeline.
package adc_pkg;

  localparam int unsigned MAX_GRID_SIDE_DEF = 1024;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic signed [63:0] ORIGIN_Q  = -64'sd327680;
  localparam logic signed [63:0] ONE_Q     = 64'sd65536;
  localparam logic signed [63:0] MILLI_Q32 = 64'sd4294967;
  localparam logic signed [63:0] HALF_Q32  = 64'sd2147483648;
  localparam logic signed [63:0] HEAT_Q    = 64'sd655360;
  localparam logic signed [32:0] VORTEX_Q  = 33'sd131072;
  localparam logic [66:0]        NEAR_SQ   = 67'd42949672;
  localparam logic [64:0]        UNIT_SQ   = 65'h1_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS   = 3'd0,
    CFG_GRID_ROWS   = 3'd1,
    CFG_CELL_WIDTH  = 3'd2,
    CFG_CELL_HEIGHT = 3'd3,
    CFG_TIME_STEP   = 3'd4,
    CFG_DIFFUSIVITY = 3'd5,
    CFG_BASE_TEMP   = 3'd6,
    CFG_BUOY_GAIN   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0]        grid_cols;
    logic [10:0]        grid_rows;
    logic [30:0]        cell_width;
    logic [30:0]        cell_height;
    logic [30:0]        time_step;
    logic [30:0]        diffusivity;
    logic signed [31:0] base_temperature;
    logic signed [31:0] buoyancy_gain;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         row;
    logic [9:0]         col;
    logic signed [31:0] center_temp;
    logic signed [31:0] north_temp;
    logic signed [31:0] south_temp;
    logic signed [31:0] west_temp;
    logic signed [31:0] east_temp;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_velocity;
    logic signed [31:0] y_velocity;
    logic signed [31:0] new_temp;
  } out_item_t;

  // Stencil operands that ride along the front end.
  typedef struct packed {
    logic signed [31:0] c;
    logic               interior;
    logic [34:0]        lap_m;
    logic               lap_neg;
    logic [32:0]        gx_m;
    logic               gx_neg;
    logic [32:0]        gy_m;
    logic               gy_neg;
    logic [61:0]        dx2;
  } carry_t;

  typedef struct packed {
    logic signed [24:0] wr_base;
    logic signed [47:0] wi_base;
    logic [32:0]        ma0;
    logic [32:0]        mb0;
    logic [32:0]        ma1;
    logic [32:0]        mb1;
    logic               na0;
    logic               nb0;
    logic               na1;
    logic               nb1;
    logic [66:0]        sq0;
    logic [66:0]        sq1;
    logic               near0;
    logic               near1;
    logic               heat;
    carry_t             tl;
  } front_t;

  // Sideband that waits beside the dividers.
  typedef struct packed {
    logic signed [24:0] wr_base;
    logic signed [47:0] wi_base;
    logic               near0;
    logic               near1;
    logic               heat;
    logic               interior;
    logic signed [31:0] c;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round a Q32.32 product half up back to Q16.16.
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return t[47:0];
  endfunction

endpackage

[design/adc_stream_if.sv]
// Valid/ready stream channel carrying one payload item.
interface adc_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/adc_delay.sv]
// Enabled shift line that keeps sideband aligned with the dividers.
module adc_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign data_o = line_q[DEPTH-1];
endmodule

[design/adc_qdiv.sv]
// Pipelined restoring divider: saturated signed (mag * 2^K) / div, one bit a stage.
module adc_qdiv #(
  parameter int unsigned MW = 33,
  parameter int unsigned DW = 31,
  parameter int unsigned K  = 15
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [MW-1:0]      mag_i,
  input  logic               neg_i,
  input  logic [DW-1:0]      div_i,
  output logic signed [31:0] quo_o
);
  localparam int unsigned QB = 31;
  localparam int unsigned NW = MW + K;
  localparam int unsigned W  = (NW > DW + QB) ? NW : DW + QB;

  logic [W-1:0]  num_q  [QB];
  logic [DW-1:0] den_q  [QB];
  logic [QB-1:0] quo_q  [QB+1];
  logic          neg_q  [QB+1];
  logic          zero_q [QB+1];
  logic          ovf_q  [QB+1];
  logic signed [31:0] res_q;

  // Quotient of 2^31 or more saturates; a zero divisor lands there too.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= W'(mag_i) << K;
      den_q[0]  <= div_i;
      quo_q[0]  <= '0;
      neg_q[0]  <= neg_i;
      zero_q[0] <= (mag_i == '0);
      ovf_q[0]  <= (W'(mag_i) << K) >= (W'(div_i) << QB);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int unsigned B = QB - 1 - s;
    logic [W-1:0] trial;
    logic         take;
    assign trial = W'(den_q[s]) << B;
    assign take  = num_q[s] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s+1]  <= quo_q[s] | (QB'(take) << B);
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
        ovf_q[s+1]  <= ovf_q[s];
      end
    end

    if (s < QB - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[s+1] <= take ? num_q[s] - trial : num_q[s];
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[QB]) res_q <= '0;
      else if (ovf_q[QB]) res_q <= neg_q[QB] ? 32'sh80000000 : 32'sh7fffffff;
      else if (neg_q[QB]) res_q <= -$signed({1'b0, quo_q[QB]});
      else res_q <= $signed({1'b0, quo_q[QB]});
    end
  end

  assign quo_o = res_q;
endmodule

[design/adc_front.sv]
// Front end: cell position, velocity base terms, vortex distances and stencil sums.
module adc_front import adc_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_GRID_SIDE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     valid_o,
  output front_t   front_o
);
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] dtemp;
    logic signed [34:0] lap_n;
    logic signed [32:0] gx_n;
    logic signed [32:0] gy_n;
    logic signed [31:0] c;
    logic               interior;
    logic [61:0]        dx2;
  } s1_t;

  typedef struct packed {
    logic signed [24:0] wr_base;
    logic signed [47:0] wi_base;
    logic signed [32:0] a0;
    logic signed [32:0] b0;
    logic signed [32:0] a1;
    logic signed [32:0] b1;
    logic signed [31:0] x;
    logic signed [31:0] y;
    carry_t             tl;
  } s2_t;

  typedef struct packed {
    logic signed [24:0] wr_base;
    logic signed [47:0] wi_base;
    logic [32:0]        ma0;
    logic [32:0]        mb0;
    logic [32:0]        ma1;
    logic [32:0]        mb1;
    logic               na0;
    logic               nb0;
    logic               na1;
    logic               nb1;
    logic [65:0]        sa0;
    logic [65:0]        sb0;
    logic [65:0]        sa1;
    logic [65:0]        sb1;
    logic [63:0]        sx;
    logic [63:0]        sy;
    carry_t             tl;
  } s3_t;

  s1_t    s1_d, s1_q;
  s2_t    s2_d, s2_q;
  s3_t    s3_d, s3_q;
  front_t s4_d, s4_q;
  logic   v1_q, v2_q, v3_q, v4_q;

  logic [31:0]        rows_lim, cols_lim;
  logic [40:0]        xp, yp;
  logic signed [63:0] wr_t, wi_p;
  logic [31:0]        mx, my;

  // Stage 1: position, temperature offset, stencil sums, border test
  always_comb begin
    rows_lim = (32'(cfg_i.grid_rows) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(cfg_i.grid_rows);
    cols_lim = (32'(cfg_i.grid_cols) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(cfg_i.grid_cols);
    xp = 41'(item_i.col) * 41'(cfg_i.cell_width);
    yp = 41'(item_i.row) * 41'(cfg_i.cell_height);
    s1_d.x = sat32($signed(64'(xp)) + ORIGIN_Q);
    s1_d.y = sat32($signed(64'(yp)) + ORIGIN_Q);
    s1_d.dtemp = sat32(64'(item_i.center_temp) - 64'(cfg_i.base_temperature));
    s1_d.lap_n = 35'(item_i.north_temp) + 35'(item_i.south_temp)
               + 35'(item_i.east_temp) + 35'(item_i.west_temp)
               - (35'(item_i.center_temp) <<< 2);
    s1_d.gx_n = 33'(item_i.east_temp) - 33'(item_i.west_temp);
    s1_d.gy_n = 33'(item_i.south_temp) - 33'(item_i.north_temp);
    s1_d.c = item_i.center_temp;
    s1_d.interior = (item_i.row != '0) && (item_i.col != '0)
                  && (32'(item_i.row) + 32'd2 <= rows_lim)
                  && (32'(item_i.col) + 32'd2 <= cols_lim);
    s1_d.dx2 = 62'(cfg_i.cell_width) * 62'(cfg_i.cell_width);
  end

  // Stage 2: velocity base terms, offsets to both vortices, magnitudes
  always_comb begin
    wr_t = ((64'(s1_q.dtemp) * MILLI_Q32 + HALF_Q32) >>> 32) + ONE_Q;
    wi_p = 64'(cfg_i.buoyancy_gain) * 64'(s1_q.dtemp);
    s2_d.wr_base = wr_t[24:0];
    s2_d.wi_base = rnd16(wi_p);
    s2_d.a0 = 33'(s1_q.x) - VORTEX_Q;
    s2_d.b0 = 33'(s1_q.y) - VORTEX_Q;
    s2_d.a1 = 33'(s1_q.x) + VORTEX_Q;
    s2_d.b1 = 33'(s1_q.y) + VORTEX_Q;
    s2_d.x = s1_q.x;
    s2_d.y = s1_q.y;
    s2_d.tl.c = s1_q.c;
    s2_d.tl.interior = s1_q.interior;
    s2_d.tl.lap_neg = s1_q.lap_n[34];
    s2_d.tl.lap_m = s1_q.lap_n[34] ? 35'(-s1_q.lap_n) : 35'(s1_q.lap_n);
    s2_d.tl.gx_neg = s1_q.gx_n[32];
    s2_d.tl.gx_m = s1_q.gx_n[32] ? 33'(-s1_q.gx_n) : 33'(s1_q.gx_n);
    s2_d.tl.gy_neg = s1_q.gy_n[32];
    s2_d.tl.gy_m = s1_q.gy_n[32] ? 33'(-s1_q.gy_n) : 33'(s1_q.gy_n);
    s2_d.tl.dx2 = s1_q.dx2;
  end

  // Stage 3: squares
  always_comb begin
    s3_d.wr_base = s2_q.wr_base;
    s3_d.wi_base = s2_q.wi_base;
    s3_d.na0 = s2_q.a0[32];
    s3_d.nb0 = s2_q.b0[32];
    s3_d.na1 = s2_q.a1[32];
    s3_d.nb1 = s2_q.b1[32];
    s3_d.ma0 = s2_q.a0[32] ? 33'(-s2_q.a0) : 33'(s2_q.a0);
    s3_d.mb0 = s2_q.b0[32] ? 33'(-s2_q.b0) : 33'(s2_q.b0);
    s3_d.ma1 = s2_q.a1[32] ? 33'(-s2_q.a1) : 33'(s2_q.a1);
    s3_d.mb1 = s2_q.b1[32] ? 33'(-s2_q.b1) : 33'(s2_q.b1);
    mx = s2_q.x[31] ? 32'(-s2_q.x) : 32'(s2_q.x);
    my = s2_q.y[31] ? 32'(-s2_q.y) : 32'(s2_q.y);
    s3_d.sa0 = 66'(s3_d.ma0) * 66'(s3_d.ma0);
    s3_d.sb0 = 66'(s3_d.mb0) * 66'(s3_d.mb0);
    s3_d.sa1 = 66'(s3_d.ma1) * 66'(s3_d.ma1);
    s3_d.sb1 = 66'(s3_d.mb1) * 66'(s3_d.mb1);
    s3_d.sx = 64'(mx) * 64'(mx);
    s3_d.sy = 64'(my) * 64'(my);
    s3_d.tl = s2_q.tl;
  end

  // Stage 4: squared distances, near tests, unit disc test
  always_comb begin
    s4_d.wr_base = s3_q.wr_base;
    s4_d.wi_base = s3_q.wi_base;
    s4_d.ma0 = s3_q.ma0;
    s4_d.mb0 = s3_q.mb0;
    s4_d.ma1 = s3_q.ma1;
    s4_d.mb1 = s3_q.mb1;
    s4_d.na0 = s3_q.na0;
    s4_d.nb0 = s3_q.nb0;
    s4_d.na1 = s3_q.na1;
    s4_d.nb1 = s3_q.nb1;
    s4_d.sq0 = 67'(s3_q.sa0) + 67'(s3_q.sb0);
    s4_d.sq1 = 67'(s3_q.sa1) + 67'(s3_q.sb1);
    s4_d.near0 = s4_d.sq0 > NEAR_SQ;
    s4_d.near1 = s4_d.sq1 > NEAR_SQ;
    s4_d.heat = (65'(s3_q.sx) + 65'(s3_q.sy)) < UNIT_SQ;
    s4_d.tl = s3_q.tl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign valid_o = v4_q;
  assign front_o = s4_q;
endmodule

[design/adc_back.sv]
// Back end: velocity sums, rate of change and explicit temperature update.
module adc_back import adc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  side_t              side_i,
  input  logic signed [31:0] qa0_i,
  input  logic signed [31:0] qb0_i,
  input  logic signed [31:0] qa1_i,
  input  logic signed [31:0] qb1_i,
  input  logic signed [31:0] qlap_i,
  input  logic signed [31:0] qgx_i,
  input  logic signed [31:0] qgy_i,
  input  cfg_t               cfg_i,
  output logic               valid_o,
  output out_item_t          item_o
);
  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] lap;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic               heat;
    logic               interior;
    logic signed [31:0] c;
  } b1_t;

  typedef struct packed {
    logic signed [47:0] kd;
    logic signed [47:0] ug;
    logic signed [47:0] vg;
    logic               heat;
    logic               interior;
    logic signed [31:0] c;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } b2_t;

  typedef struct packed {
    logic signed [31:0] rate;
    logic               interior;
    logic signed [31:0] c;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } b3_t;

  b1_t       b1_d, b1_q;
  b2_t       b2_d, b2_q;
  b3_t       b3_d, b3_q;
  out_item_t b4_d, b4_q;
  logic      v1_q, v2_q, v3_q, v4_q;

  logic signed [35:0] wr;
  logic signed [49:0] wi;
  logic signed [63:0] rate_w, step_p;

  // Add vortex terms only where the cell is clear of the core
  always_comb begin
    wr = 36'(side_i.wr_base) + (side_i.near0 ? 36'(qa0_i) : 36'sd0)
       + (side_i.near1 ? 36'(qa1_i) : 36'sd0);
    wi = 50'(side_i.wi_base) - (side_i.near0 ? 50'(qb0_i) : 50'sd0)
       - (side_i.near1 ? 50'(qb1_i) : 50'sd0);
    b1_d.u = sat32(64'(wr));
    b1_d.v = sat32(64'(wi));
    b1_d.lap = qlap_i;
    b1_d.gx = qgx_i;
    b1_d.gy = qgy_i;
    b1_d.heat = side_i.heat;
    b1_d.interior = side_i.interior;
    b1_d.c = side_i.c;
  end

  always_comb begin
    b2_d.kd = rnd16(64'($signed({1'b0, cfg_i.diffusivity})) * 64'(b1_q.lap));
    b2_d.ug = rnd16(64'(b1_q.u) * 64'(b1_q.gx));
    b2_d.vg = rnd16(64'(b1_q.v) * 64'(b1_q.gy));
    b2_d.heat = b1_q.heat;
    b2_d.interior = b1_q.interior;
    b2_d.c = b1_q.c;
    b2_d.u = b1_q.u;
    b2_d.v = b1_q.v;
  end

  always_comb begin
    rate_w = 64'(b2_q.kd) - 64'(b2_q.ug) - 64'(b2_q.vg) + (b2_q.heat ? HEAT_Q : 64'sd0);
    b3_d.rate = sat32(rate_w);
    b3_d.interior = b2_q.interior;
    b3_d.c = b2_q.c;
    b3_d.u = b2_q.u;
    b3_d.v = b2_q.v;
  end

  // Border cells keep their temperature
  always_comb begin
    step_p = 64'($signed({1'b0, cfg_i.time_step})) * 64'(b3_q.rate);
    b4_d.x_velocity = b3_q.u;
    b4_d.y_velocity = b3_q.v;
    b4_d.new_temp = b3_q.interior ? sat32(64'(b3_q.c) + 64'(rnd16(step_p))) : b3_q.c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      b4_q <= b4_d;
    end
  end

  assign valid_o = v4_q;
  assign item_o = b4_q;
endmodule

[design/advection_diffusion_cell_update.sv]
// Top level of the advection-diffusion cell update pipeline.
//
//   channel   direction  payload
//   in_i      sink       row, col, center/north/south/west/east temperature
//   out_o     source     x_velocity, y_velocity, new_temp
//   cfg_*     write      register index, 32 bit data
//
// One cell per cycle sustained while the output is not held; 4 front stages, 33 in the
// seven bit-per-stage dividers (vortex, Laplacian, gradients), 4 back stages.
// Reset clears all valid bits and loads the default register values.
// A stalled output freezes every stage at once; in_i.ready is low exactly then.
`include "advection_diffusion_cell_update_assert.svh"
module advection_diffusion_cell_update import adc_pkg::*; #(
  parameter int unsigned MAX_GRID_SIDE = MAX_GRID_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  adc_stream_if.sink            in_i,
  adc_stream_if.source          out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned SW = $bits(side_t);
  localparam int unsigned DIV_LAT = 33;

  cfg_t      cfg_q;
  logic      adv;
  logic      front_valid;
  front_t    front;
  side_t     side_in, side_out;
  logic [SW:0] dly_in, dly_out;
  logic signed [31:0] qa0, qb0, qa1, qb1, qlap, qgx, qgy;
  logic      back_valid;
  out_item_t back_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols        <= 11'd100;
      cfg_q.grid_rows        <= 11'd100;
      cfg_q.cell_width       <= 31'd6554;
      cfg_q.cell_height      <= 31'd6554;
      cfg_q.time_step        <= 31'd655;
      cfg_q.diffusivity      <= 31'd6554;
      cfg_q.base_temperature <= 32'sd39321600;
      cfg_q.buoyancy_gain    <= 32'sd643;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_COLS:   cfg_q.grid_cols        <= cfg_data_i[10:0];
        CFG_GRID_ROWS:   cfg_q.grid_rows        <= cfg_data_i[10:0];
        CFG_CELL_WIDTH:  cfg_q.cell_width       <= cfg_data_i[30:0];
        CFG_CELL_HEIGHT: cfg_q.cell_height      <= cfg_data_i[30:0];
        CFG_TIME_STEP:   cfg_q.time_step        <= cfg_data_i[30:0];
        CFG_DIFFUSIVITY: cfg_q.diffusivity      <= cfg_data_i[30:0];
        CFG_BASE_TEMP:   cfg_q.base_temperature <= $signed(cfg_data_i);
        CFG_BUOY_GAIN:   cfg_q.buoyancy_gain    <= $signed(cfg_data_i);
      endcase
    end
  end

  // Advance the whole pipe unless a finished result is held
  assign adv = !back_valid || out_o.ready;
  assign in_i.ready = adv;

  adc_front #(.MAX_SIDE(MAX_GRID_SIDE)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .item_i  (in_i.data),
    .cfg_i   (cfg_q),
    .valid_o (front_valid),
    .front_o (front)
  );

  adc_qdiv #(.MW(33), .DW(67), .K(31)) u_div_a0 (
    .clk_i(clk_i), .en_i(adv), .mag_i(front.ma0), .neg_i(front.na0),
    .div_i(front.sq0), .quo_o(qa0)
  );
  adc_qdiv #(.MW(33), .DW(67), .K(31)) u_div_b0 (
    .clk_i(clk_i), .en_i(adv), .mag_i(front.mb0), .neg_i(front.nb0),
    .div_i(front.sq0), .quo_o(qb0)
  );
  adc_qdiv #(.MW(33), .DW(67), .K(31)) u_div_a1 (
    .clk_i(clk_i), .en_i(adv), .mag_i(front.ma1), .neg_i(front.na1),
    .div_i(front.sq1), .quo_o(qa1)
  );
  adc_qdiv #(.MW(33), .DW(67), .K(31)) u_div_b1 (
    .clk_i(clk_i), .en_i(adv), .mag_i(front.mb1), .neg_i(front.nb1),
    .div_i(front.sq1), .quo_o(qb1)
  );
  adc_qdiv #(.MW(35), .DW(62), .K(32)) u_div_lap (
    .clk_i(clk_i), .en_i(adv), .mag_i(front.tl.lap_m), .neg_i(front.tl.lap_neg),
    .div_i(front.tl.dx2), .quo_o(qlap)
  );
  adc_qdiv #(.MW(33), .DW(31), .K(15)) u_div_gx (
    .clk_i(clk_i), .en_i(adv), .mag_i(front.tl.gx_m), .neg_i(front.tl.gx_neg),
    .div_i(cfg_q.cell_width), .quo_o(qgx)
  );
  adc_qdiv #(.MW(33), .DW(31), .K(15)) u_div_gy (
    .clk_i(clk_i), .en_i(adv), .mag_i(front.tl.gy_m), .neg_i(front.tl.gy_neg),
    .div_i(cfg_q.cell_height), .quo_o(qgy)
  );

  always_comb begin
    side_in.wr_base  = front.wr_base;
    side_in.wi_base  = front.wi_base;
    side_in.near0    = front.near0;
    side_in.near1    = front.near1;
    side_in.heat     = front.heat;
    side_in.interior = front.tl.interior;
    side_in.c        = front.tl.c;
  end

  assign dly_in = {front_valid, side_in};

  adc_delay #(.WIDTH(SW + 1), .DEPTH(DIV_LAT)) u_delay (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .data_i (dly_in),
    .data_o (dly_out)
  );

  assign side_out = side_t'(dly_out[SW-1:0]);

  adc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (dly_out[SW]),
    .side_i  (side_out),
    .qa0_i   (qa0),
    .qb0_i   (qb0),
    .qa1_i   (qa1),
    .qb1_i   (qb1),
    .qlap_i  (qlap),
    .qgx_i   (qgx),
    .qgy_i   (qgy),
    .cfg_i   (cfg_q),
    .valid_o (back_valid),
    .item_o  (back_item)
  );

  assign out_o.valid = back_valid;
  assign out_o.data  = back_item;

  `ADC_ASSERT_NXT(a_div_hold, !adv, $stable(dly_out[SW]), "divider stage valid moved in a stall")
  `ADC_ASSERT_NXT(a_front_keep, front_valid && !adv, front_valid, "front request lost in a stall")
  `ADC_ASSERT_IMP(a_in_block, out_o.valid && !out_o.ready, !in_i.ready, "request taken while output held")
endmodule

[tb/advection_diffusion_cell_update_test.sv]
// Testbench of the advection-diffusion cell update: streams cells, predicts and checks results.
`timescale 1ns / 100ps
module advection_diffusion_cell_update_test;
  import adc_pkg::*;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  adc_stream_if #(.T(in_item_t))  cell_ch ();
  adc_stream_if #(.T(out_item_t)) update_ch ();

  advection_diffusion_cell_update i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cell_ch),
    .out_o      (update_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register image used by the predictor.
  int unsigned m_cols, m_rows;
  longint m_dx, m_dy, m_dt, m_kappa, m_t0, m_gain;

  in_item_t  cell_queue[$];
  out_item_t update_queue[$];
  int unsigned accepted_cnt;
  int unsigned err_cnt;
  int unsigned send_gap, recv_gap, hold_left;
  bit hold_done;
  bit steady;

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  function automatic longint clamp32(longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint round_q(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  // n * 2^k / d truncated toward zero, saturated.
  function automatic longint frac_div(longint n, longint unsigned d, int k);
    longint unsigned m, q, r;
    bit neg;
    bit digit;
    m = magnitude(n);
    neg = n < 0;
    if (m == 0) return 0;
    if (d == 0) return neg ? S32_LO : S32_HI;
    q = m / d;
    r = m % d;
    if (q > 64'h8000_0000) return neg ? S32_LO : S32_HI;
    for (int i = 0; i < k; i++) begin
      digit = 0;
      if (r >= d - r) begin
        r = r - (d - r);
        digit = 1;
      end else begin
        r = r + r;
      end
      q = q * 2 + digit;
      if (q > 64'h8000_0000) return neg ? S32_LO : S32_HI;
    end
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic out_item_t predict_cell(in_item_t it);
    longint x, y, dtemp, wr, wi, a, b, p, lap, gx, gy, rate, nt, u, v;
    longint c, nn, ss, ww, ee;
    longint unsigned sq;
    int unsigned rows_eff, cols_eff;
    out_item_t res;
    c  = longint'($signed(it.center_temp));
    nn = longint'($signed(it.north_temp));
    ss = longint'($signed(it.south_temp));
    ww = longint'($signed(it.west_temp));
    ee = longint'($signed(it.east_temp));
    x = clamp32(ORIGIN_Q + longint'({54'd0, it.col}) * m_dx);
    y = clamp32(ORIGIN_Q + longint'({54'd0, it.row}) * m_dy);
    dtemp = clamp32(c - m_t0);
    wr = ONE_Q + ((dtemp * MILLI_Q32 + HALF_Q32) >>> 32);
    wi = round_q(m_gain * dtemp);
    for (int s = 0; s < 2; s++) begin
      p = (s == 0) ? longint'(VORTEX_Q) : -longint'(VORTEX_Q);
      a = x - p;
      b = y - p;
      sq = magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b);
      if (sq > NEAR_SQ) begin
        wr += frac_div(a, sq, 31);
        wi -= frac_div(b, sq, 31);
      end
    end
    u = clamp32(wr);
    v = clamp32(wi);
    rows_eff = m_rows > MAX_GRID_SIDE_DEF ? MAX_GRID_SIDE_DEF : m_rows;
    cols_eff = m_cols > MAX_GRID_SIDE_DEF ? MAX_GRID_SIDE_DEF : m_cols;
    nt = c;
    if (it.row >= 1 && it.col >= 1 && it.row + 2 <= rows_eff && it.col + 2 <= cols_eff) begin
      lap = frac_div(nn + ss + ee + ww - 4 * c, longint'(m_dx) * longint'(m_dx), 32);
      gx = frac_div(ee - ww, m_dx, 15);
      gy = frac_div(ss - nn, m_dy, 15);
      rate = round_q(m_kappa * lap) - round_q(u * gx) - round_q(v * gy);
      if (magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y) < UNIT_SQ)
        rate += HEAT_Q;
      rate = clamp32(rate);
      nt = clamp32(c + round_q(m_dt * rate));
    end
    res.x_velocity = u[31:0];
    res.y_velocity = v[31:0];
    res.new_temp   = nt[31:0];
    return res;
  endfunction

  // Driver: offer pending cells, record the expected update on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_ch.valid <= 1'b0;
      cell_ch.data  <= '0;
      send_gap      <= 0;
      accepted_cnt  <= 0;
    end else if (!cell_ch.valid || cell_ch.ready) begin
      if (cell_ch.valid) begin
        update_queue.push_back(predict_cell(cell_ch.data));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (send_gap > 0) begin
        cell_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cell_queue.size() > 0) begin
        cell_ch.data  <= cell_queue.pop_front();
        cell_ch.valid <= 1'b1;
        send_gap <= steady ? 0 : $urandom_range(0, 7);
      end else begin
        cell_ch.valid <= 1'b0;
      end
    end
  end

  // Long hold-off on the result side once traffic is flowing.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned draw;
    if (!rst_ni) begin
      update_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else if (hold_left > 0) begin
      update_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      update_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (update_ch.valid && update_ch.ready) begin
      draw = steady ? 0 : $urandom_range(0, 7);
      update_ch.ready <= (draw == 0);
      recv_gap <= draw > 0 ? draw - 1 : 0;
    end else begin
      update_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && update_ch.valid && update_ch.ready) begin
      got = update_ch.data;
      if (update_queue.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected update %h", got);
      end else begin
        want = update_queue.pop_front();
        if (got.x_velocity !== want.x_velocity || got.y_velocity !== want.y_velocity ||
            got.new_temp !== want.new_temp) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: u exp %h got %h, v exp %h got %h, T exp %h got %h",
                     want.x_velocity, got.x_velocity, want.y_velocity, got.y_velocity,
                     want.new_temp, got.new_temp);
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_GRID_COLS:   m_cols  = val[10:0];
      CFG_GRID_ROWS:   m_rows  = val[10:0];
      CFG_CELL_WIDTH:  m_dx    = val[30:0];
      CFG_CELL_HEIGHT: m_dy    = val[30:0];
      CFG_TIME_STEP:   m_dt    = val[30:0];
      CFG_DIFFUSIVITY: m_kappa = val[30:0];
      CFG_BASE_TEMP:   m_t0    = longint'($signed(val));
      CFG_BUOY_GAIN:   m_gain  = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (cell_queue.size() > 0 || cell_ch.valid || update_queue.size() > 0)
      @(posedge clk_i);
    repeat (48) @(posedge clk_i);
  endtask

  function automatic in_item_t make_cell(int r, int c, logic [31:0] t, logic [31:0] n,
                                         logic [31:0] s, logic [31:0] w, logic [31:0] e);
    in_item_t it;
    it.row = 10'(r);
    it.col = 10'(c);
    it.center_temp = t;
    it.north_temp  = n;
    it.south_temp  = s;
    it.west_temp   = w;
    it.east_temp   = e;
    return it;
  endfunction

  function automatic logic [31:0] pick_spacing();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'h7fff_ffff;
      3: return $urandom();
      default: return $urandom_range(2000, 70000);
    endcase
  endfunction

  function automatic logic [31:0] pick_side();
    case ($urandom_range(0, 4))
      0: return 32'd3;
      1: return 32'd1024;
      2: return $urandom_range(1025, 2047);
      3: return $urandom_range(0, 2);
      default: return $urandom_range(4, 200);
    endcase
  endfunction

  function automatic in_item_t random_cell();
    in_item_t it;
    int unsigned lim_r, lim_c;
    logic [31:0] t;
    logic [191:0] raw;
    lim_r = m_rows > 1023 ? 1023 : m_rows;
    lim_c = m_cols > 1023 ? 1023 : m_cols;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = $urandom_range(0, 3) == 0 ? in_item_t'(raw[$bits(in_item_t)-1:0]) : '0;
    if ($urandom_range(0, 3) != 0) begin
      it.row = 10'($urandom_range(0, lim_r));
      it.col = 10'($urandom_range(0, lim_c));
      t = 32'(m_t0) + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      it.center_temp = t;
      it.north_temp  = t + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      it.south_temp  = t + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      it.west_temp   = t + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      it.east_temp   = t + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    end else if (it == '0) begin
      it = in_item_t'(raw[$bits(in_item_t)-1:0]);
    end
    return it;
  endfunction

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    steady     = 1'b0;
    err_cnt    = 0;
    m_cols = 100; m_rows = 100; m_dx = 6554; m_dy = 6554;
    m_dt = 655; m_kappa = 6554; m_t0 = 39321600; m_gain = 643;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed cells under the reset settings: borders, corners, heat disc, vortices.
    cell_queue.push_back(make_cell(0, 0, 32'd39321600, 0, 0, 0, 0));
    cell_queue.push_back(make_cell(1, 1, 32'd39321600, 32'd39000000, 32'd40000000,
                                   32'd38000000, 32'd41000000));
    cell_queue.push_back(make_cell(98, 98, 32'd40000000, 32'd39321600, 32'd39321600,
                                   32'd39321600, 32'd39321600));
    cell_queue.push_back(make_cell(99, 99, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5));
    cell_queue.push_back(make_cell(98, 1, 0, 0, 0, 0, 0));
    cell_queue.push_back(make_cell(50, 50, 32'd39321600, 32'd39321600, 32'd39321600,
                                   32'd39321600, 32'd39321600));
    cell_queue.push_back(make_cell(45, 55, 32'd39000000, 32'd39100000, 32'd39200000,
                                   32'd39300000, 32'd39400000));
    cell_queue.push_back(make_cell(70, 70, 32'd39321600, 32'd39321700, 32'd39321500,
                                   32'd39321000, 32'd39322000));
    cell_queue.push_back(make_cell(30, 30, 32'd39321600, 32'd0, 32'd65536, 32'd0,
                                   32'd65536));
    cell_queue.push_back(make_cell(71, 71, 32'd39321600, 32'd39321600, 32'd39321600,
                                   32'd39321600, 32'd39321600));
    cell_queue.push_back(make_cell(1023, 1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                   32'h7fff_ffff, 32'h7fff_ffff));
    cell_queue.push_back(make_cell(50, 50, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000));
    cell_queue.push_back(make_cell(20, 20, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                   32'h7fff_ffff, 32'h8000_0000));
    cell_queue.push_back(make_cell(20, 20, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                   32'h8000_0000, 32'h7fff_ffff));
    cell_queue.push_back(make_cell(1023, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                   32'hffff_ffff, 32'hffff_ffff));
    cell_queue.push_back(make_cell(0, 1023, 0, 0, 0, 0, 0));
    drain();

    // Random phases; the first two force the register extremes.
    for (int ph = 0; ph < 6; ph++) begin
      steady = (ph == 3);
      if (ph == 0) begin
        write_reg(CFG_GRID_COLS, 32'd3);
        write_reg(CFG_GRID_ROWS, 32'd3);
        write_reg(CFG_CELL_WIDTH, 32'd1);
        write_reg(CFG_CELL_HEIGHT, 32'd1);
        write_reg(CFG_TIME_STEP, 32'd0);
        write_reg(CFG_DIFFUSIVITY, 32'd0);
        write_reg(CFG_BASE_TEMP, 32'h8000_0000);
        write_reg(CFG_BUOY_GAIN, 32'h8000_0000);
      end else if (ph == 1) begin
        write_reg(CFG_GRID_COLS, 32'd2047);
        write_reg(CFG_GRID_ROWS, 32'd1024);
        write_reg(CFG_CELL_WIDTH, 32'h7fff_ffff);
        write_reg(CFG_CELL_HEIGHT, 32'h7fff_ffff);
        write_reg(CFG_TIME_STEP, 32'h7fff_ffff);
        write_reg(CFG_DIFFUSIVITY, 32'h7fff_ffff);
        write_reg(CFG_BASE_TEMP, 32'h7fff_ffff);
        write_reg(CFG_BUOY_GAIN, 32'h7fff_ffff);
      end else begin
        write_reg(CFG_GRID_COLS, pick_side());
        write_reg(CFG_GRID_ROWS, pick_side());
        write_reg(CFG_CELL_WIDTH, pick_spacing());
        write_reg(CFG_CELL_HEIGHT, pick_spacing());
        write_reg(CFG_TIME_STEP, $urandom_range(0, 3) == 0 ? $urandom() :
                                 $urandom_range(0, 5000));
        write_reg(CFG_DIFFUSIVITY, $urandom_range(0, 3) == 0 ? $urandom() :
                                   $urandom_range(0, 20000));
        write_reg(CFG_BASE_TEMP, $urandom_range(0, 2) == 0 ? $urandom() :
                                 $urandom_range(0, 32'h0400_0000));
        write_reg(CFG_BUOY_GAIN, $urandom_range(0, 2) == 0 ? $urandom() :
                                 $urandom_range(0, 4000));
      end
      for (int k = 0; k < 258; k++) cell_queue.push_back(random_cell());
      drain();
    end

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("simulation failed");
    $finish;
  end

endmodule
